// File: rtl/mhpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the max-heap priority queue: field widths,
// command and status codes, datapath operations and datapath status.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int DEF_CAPACITY = 128;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 8;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_PEEK    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INS_START,
        OP_EXT_START,
        OP_CLEAR,
        OP_PEEK,
        OP_SET_FULL,
        OP_SET_EMPTY,
        OP_EX_LATCH,
        OP_UP_READ,
        OP_UP_STEP,
        OP_UP_PLACE,
        OP_DN_READ_L,
        OP_DN_LEFT,
        OP_DN_STEP,
        OP_TOP_READ,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic one_left;
        logic at_root;
        logic l_in;
        logic up_gt;
        logic dn_move;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/mhpq_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_cmd_if
// Command channel: valid/ready handshake with a command code and a value.
// ----------------------------------------------------------------------------
interface mhpq_cmd_if;
    import mhpq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface
`default_nettype wire

// File: rtl/mhpq_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_res_if
// Result channel: valid/ready handshake with top value, count and status.
// ----------------------------------------------------------------------------
interface mhpq_res_if;
    import mhpq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] top_value;
    logic [COUNT_W-1:0]        entry_count;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, output top_value, output entry_count, output status,
                    input ready);
    modport sink   (input valid, input top_value, input entry_count, input status,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/mhpq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_datapath
// Heap memory, fill count, sift position and moving value, comparators and
// result registers. Performs one operation per cycle as commanded.
// ----------------------------------------------------------------------------
module mhpq_datapath #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mhpq_pkg::dp_op_t                   op,
    input  wire logic signed [mhpq_pkg::VALUE_W-1:0] value,
    output mhpq_pkg::dp_stat_t                      stat,
    output logic signed [mhpq_pkg::VALUE_W-1:0]     top_value,
    output logic [mhpq_pkg::COUNT_W-1:0]            entry_count,
    output logic [mhpq_pkg::STATUS_W-1:0]           status
);
    import mhpq_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = IW + 2;

    logic signed [VALUE_W-1:0] mem [CAPACITY];

    logic [CW-1:0]             cnt_reg, cnt_next;
    status_t                   st_reg, st_next;
    logic [IW-1:0]             pos_reg, pos_next;
    logic signed [VALUE_W-1:0] cur_reg, cur_next;
    logic signed [VALUE_W-1:0] lval_reg, lval_next;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic signed [VALUE_W-1:0] res_top_reg, res_top_next;
    logic [COUNT_W-1:0]        res_cnt_reg, res_cnt_next;
    status_t                   res_st_reg, res_st_next;

    logic                      mem_we, mem_re;
    logic [IW-1:0]             waddr, raddr;
    logic signed [VALUE_W-1:0] wdata;

    logic [EW-1:0]             l_ext, r_ext, cnt_ext;
    logic [IW-1:0]             parent;
    logic                      l_in, r_in, up_gt, l_gt, r_gt, dn_move;
    logic signed [VALUE_W-1:0] best_val, dn_val;
    logic [IW-1:0]             dn_idx;

    // child and parent positions
    assign l_ext   = (EW'(pos_reg) << 1) + EW'(1);
    assign r_ext   = l_ext + EW'(1);
    assign cnt_ext = EW'(cnt_reg);
    assign l_in    = l_ext < cnt_ext;
    assign r_in    = r_ext < cnt_ext;
    assign parent  = IW'((pos_reg - IW'(1)) >> 1);

    // comparisons, left child wins ties
    assign up_gt    = cur_reg > rd_data_reg;
    assign l_gt     = lval_reg > cur_reg;
    assign best_val = l_gt ? lval_reg : cur_reg;
    assign r_gt     = r_in && (rd_data_reg > best_val);
    assign dn_move  = l_gt || r_gt;
    assign dn_val   = r_gt ? rd_data_reg : lval_reg;
    assign dn_idx   = r_gt ? r_ext[IW-1:0] : l_ext[IW-1:0];

    assign stat.full     = cnt_reg == CW'(CAPACITY);
    assign stat.empty    = cnt_reg == '0;
    assign stat.one_left = cnt_reg == CW'(1);
    assign stat.at_root  = pos_reg == '0;
    assign stat.l_in     = l_in;
    assign stat.up_gt    = up_gt;
    assign stat.dn_move  = dn_move;

    always_comb
    begin
        cnt_next     = cnt_reg;
        st_next      = st_reg;
        pos_next     = pos_reg;
        cur_next     = cur_reg;
        lval_next    = lval_reg;
        res_top_next = res_top_reg;
        res_cnt_next = res_cnt_reg;
        res_st_next  = res_st_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        waddr        = pos_reg;
        raddr        = '0;
        wdata        = cur_reg;
        case (op)
            OP_INS_START:
            begin
                cnt_next = cnt_reg + CW'(1);
                pos_next = IW'(cnt_reg);
                cur_next = value;
                st_next  = ST_DONE;
            end
            OP_EXT_START:
            begin
                mem_re   = 1'b1;
                raddr    = IW'(cnt_reg - CW'(1));
                cnt_next = cnt_reg - CW'(1);
                pos_next = '0;
                st_next  = ST_DONE;
            end
            OP_CLEAR:
            begin
                cnt_next = '0;
                st_next  = ST_DONE;
            end
            OP_PEEK:      st_next = ST_DONE;
            OP_SET_FULL:  st_next = ST_FULL;
            OP_SET_EMPTY: st_next = ST_EMPTY;
            OP_EX_LATCH:  cur_next = rd_data_reg;
            OP_UP_READ:
            begin
                mem_re = 1'b1;
                raddr  = parent;
            end
            OP_UP_STEP:
            begin
                mem_we = 1'b1;
                if (up_gt)
                begin
                    wdata    = rd_data_reg;
                    pos_next = parent;
                end
            end
            OP_UP_PLACE:  mem_we = 1'b1;
            OP_DN_READ_L:
            begin
                mem_re = 1'b1;
                raddr  = l_ext[IW-1:0];
            end
            OP_DN_LEFT:
            begin
                lval_next = rd_data_reg;
                mem_re    = 1'b1;
                raddr     = r_ext[IW-1:0];
            end
            OP_DN_STEP:
            begin
                mem_we = 1'b1;
                if (dn_move)
                begin
                    wdata    = dn_val;
                    pos_next = dn_idx;
                end
            end
            OP_TOP_READ:
            begin
                mem_re = 1'b1;
                raddr  = '0;
            end
            OP_RESULT:
            begin
                res_top_next = (cnt_reg == '0) ? '0 : rd_data_reg;
                res_cnt_next = COUNT_W'(cnt_reg);
                res_st_next  = st_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            st_reg  <= ST_DONE;
        end
        else
        begin
            cnt_reg <= cnt_next;
            st_reg  <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        cur_reg     <= cur_next;
        lval_reg    <= lval_next;
        res_top_reg <= res_top_next;
        res_cnt_reg <= res_cnt_next;
        res_st_reg  <= res_st_next;
    end

    // heap memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign top_value   = res_top_reg;
    assign entry_count = res_cnt_reg;
    assign status      = res_st_reg;

endmodule
`default_nettype wire

// File: rtl/mhpq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for the heap: takes one command transaction, steps the sift up
// or sift down through the datapath, then hands the result to the output.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [mhpq_pkg::CMD_W-1:0]    command,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    input  wire mhpq_pkg::dp_stat_t            stat,
    output mhpq_pkg::dp_op_t                   op
);
    import mhpq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_EX_LOAD,
        S_DN_CHK,
        S_DN_RL,
        S_DN_RR,
        S_TOP_RD,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   res_valid_reg, res_valid_next;
    logic   out_free;

    assign out_free = !res_valid_reg || res_ready;

    always_comb
    begin
        state_next     = state_reg;
        op             = OP_NONE;
        res_valid_next = res_valid_reg && !res_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd_t'(command))
                        CMD_INSERT:
                        begin
                            if (stat.full)
                            begin
                                op         = OP_SET_FULL;
                                state_next = S_TOP_RD;
                            end
                            else
                            begin
                                op         = OP_INS_START;
                                state_next = S_UP_CHK;
                            end
                        end
                        CMD_EXTRACT:
                        begin
                            if (stat.empty)
                            begin
                                op         = OP_SET_EMPTY;
                                state_next = S_TOP_RD;
                            end
                            else
                            begin
                                op         = OP_EXT_START;
                                state_next = stat.one_left ? S_TOP_RD : S_EX_LOAD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            op         = OP_CLEAR;
                            state_next = S_TOP_RD;
                        end
                        default:
                        begin
                            op         = OP_PEEK;
                            state_next = S_TOP_RD;
                        end
                    endcase
                end
            end
            S_UP_CHK:
            begin
                if (stat.at_root)
                begin
                    op         = OP_UP_PLACE;
                    state_next = S_TOP_RD;
                end
                else
                begin
                    op         = OP_UP_READ;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                op         = OP_UP_STEP;
                state_next = stat.up_gt ? S_UP_CHK : S_TOP_RD;
            end
            S_EX_LOAD:
            begin
                op         = OP_EX_LATCH;
                state_next = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (stat.l_in)
                begin
                    op         = OP_DN_READ_L;
                    state_next = S_DN_RL;
                end
                else
                begin
                    op         = OP_UP_PLACE;
                    state_next = S_TOP_RD;
                end
            end
            S_DN_RL:
            begin
                op         = OP_DN_LEFT;
                state_next = S_DN_RR;
            end
            S_DN_RR:
            begin
                op         = OP_DN_STEP;
                state_next = stat.dn_move ? S_DN_CHK : S_TOP_RD;
            end
            S_TOP_RD:
            begin
                op         = OP_TOP_READ;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    op             = OP_RESULT;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ready_next = state_next == S_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ready_reg     <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign in_ready  = ready_reg;
    assign res_valid = res_valid_reg;

endmodule
`default_nettype wire

// File: rtl/max_heap_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Bounded binary max-heap of signed 32-bit values with insert, extract
// maximum, clear and peek; one result transaction per command transaction.
//
//   channel  dir  payload                              transaction
//   cmd      in   command[1:0], value[31:0]            valid & ready
//   res      out  top_value[31:0], entry_count[7:0],   valid & ready
//                 status[1:0]
//
// one command at a time; the heap memory port sets the pace
// insert: start, then a parent read and a compare step per parent compared,
// a place step when the value reaches the root, then top read and result
// extract: start and load, then per level with children a check with left read,
// a right read and a compare step; a place step when the value lands with no children left
// clear and peek: straight to top read and result; full, empty and last-entry extract likewise
// a finished result sits in the output register, the next command is taken
// while it waits; a stalled output holds the sequencer before the result load
// reset clears the fill count, the heap memory itself is not cleared
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mhpq_cmd_if.sink   cmd,
    mhpq_res_if.source res
);
    import mhpq_pkg::*;

    dp_op_t   op;
    dp_stat_t stat;

    mhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .command   (cmd.command),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .stat      (stat),
        .op        (op)
    );

    mhpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .value       (cmd.value),
        .stat        (stat),
        .top_value   (res.top_value),
        .entry_count (res.entry_count),
        .status      (res.status)
    );

    // one command in flight: no second transaction straight after a first
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("command taken while another is in flight");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.status == ST_EMPTY) |-> res.entry_count == '0)
        else $error("empty status with non-zero count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.status == ST_FULL) |-> res.entry_count == COUNT_W'(CAPACITY))
        else $error("full status with count below capacity");

    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.full && stat.empty))
        else $error("heap reported both full and empty");

endmodule
`default_nettype wire

// File: tb/max_heap_priority_queue_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// max_heap_priority_queue_tb
// Self-checking bench for the max-heap priority queue. A shadow heap predicts
// the top value, entry count and status for every accepted command
// transaction. Each result transaction is compared field by field with the
// oldest prediction. Directed tests cover the empty heap, extreme values and a
// completely full heap. A long random mix follows, with bursts of idling on
// both channels, and the run ends with back-to-back traffic.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_tb;
    import mhpq_pkg::*;

    localparam int CAPACITY    = DEF_CAPACITY;
    localparam int CYCLE_LIMIT = 250000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] top_value;
        logic [COUNT_W-1:0]        entry_count;
        status_t                   status;
    } heap_answer_t;

    logic clk;
    logic rst_n;

    mhpq_cmd_if cmd_if ();
    mhpq_res_if res_if ();

    max_heap_priority_queue #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    logic signed [VALUE_W-1:0] shadow_heap [CAPACITY];
    int                        shadow_fill;
    heap_answer_t              pending_answers [$];

    bit idle_on;
    int stall_left;
    int cycle_count;
    int error_count;
    int answers_checked;
    int n_insert;
    int n_extract;
    int n_clear;
    int n_peek;
    int n_dropped;
    int n_ignored;

    always #6 clk = ~clk;

    // shadow heap update, one call per accepted command transaction
    function automatic heap_answer_t apply_command(input cmd_t op,
                                                   input logic signed [VALUE_W-1:0] v);
        heap_answer_t              answer;
        logic signed [VALUE_W-1:0] held;
        int                        pos;
        int                        parent;
        int                        left;
        int                        right;
        int                        best;
        bit                        settled;
        answer.status = ST_DONE;
        case (op)
            CMD_INSERT:
            begin
                if (shadow_fill >= CAPACITY)
                    answer.status = ST_FULL;
                else
                begin
                    pos = shadow_fill;
                    shadow_heap[pos] = v;
                    shadow_fill++;
                    settled = 1'b0;
                    while (pos > 0 && !settled)
                    begin
                        parent = (pos - 1) / 2;
                        if (shadow_heap[pos] > shadow_heap[parent])
                        begin
                            held = shadow_heap[pos];
                            shadow_heap[pos] = shadow_heap[parent];
                            shadow_heap[parent] = held;
                            pos = parent;
                        end
                        else
                            settled = 1'b1;
                    end
                end
            end
            CMD_EXTRACT:
            begin
                if (shadow_fill == 0)
                    answer.status = ST_EMPTY;
                else
                begin
                    shadow_heap[0] = shadow_heap[shadow_fill - 1];
                    shadow_fill--;
                    pos = 0;
                    settled = 1'b0;
                    while (!settled)
                    begin
                        left  = 2 * pos + 1;
                        right = 2 * pos + 2;
                        best  = pos;
                        if (left < shadow_fill && shadow_heap[left] > shadow_heap[best])
                            best = left;
                        if (right < shadow_fill && shadow_heap[right] > shadow_heap[best])
                            best = right;
                        if (best == pos)
                            settled = 1'b1;
                        else
                        begin
                            held = shadow_heap[pos];
                            shadow_heap[pos] = shadow_heap[best];
                            shadow_heap[best] = held;
                            pos = best;
                        end
                    end
                end
            end
            CMD_CLEAR:
                shadow_fill = 0;
            default:
                ;
        endcase
        answer.top_value   = (shadow_fill == 0) ? '0 : shadow_heap[0];
        answer.entry_count = shadow_fill[COUNT_W-1:0];
        return answer;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 7))
            0, 1:    v = $signed($urandom_range(0, 16)) - 8;
            2:       v = 32'sh7FFF_FFFF - $signed($urandom_range(0, 3));
            3:       v = 32'sh8000_0000 + $signed($urandom_range(0, 3));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic cmd_t pick_command(input int insert_weight);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < insert_weight)
            return CMD_INSERT;
        else if (roll < 88)
            return CMD_EXTRACT;
        else if (roll < 97)
            return CMD_PEEK;
        else
            return CMD_CLEAR;
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] want,
                                   input logic [VALUE_W-1:0] got);
        $display("%0t: mismatch in %s, expected %0h got %0h", $realtime, what, want, got);
        error_count++;
    endtask

    // entered and left at a falling edge
    task automatic send_command(input cmd_t op, input logic signed [VALUE_W-1:0] v);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 13);
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= op;
        cmd_if.value   <= v;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        pending_answers.push_back(apply_command(op, v));
        case (op)
            CMD_INSERT:  n_insert++;
            CMD_EXTRACT: n_extract++;
            CMD_CLEAR:   n_clear++;
            default:     n_peek++;
        endcase
        if (pending_answers[$].status == ST_FULL)
            n_dropped++;
        if (pending_answers[$].status == ST_EMPTY)
            n_ignored++;
        @(negedge clk);
    endtask

    task automatic test_empty_heap();
        send_command(CMD_PEEK, 32'sd0);
        send_command(CMD_EXTRACT, 32'sd5);
        send_command(CMD_CLEAR, -32'sd1);
        send_command(CMD_PEEK, 32'sh7FFF_FFFF);
    endtask

    task automatic test_extreme_values();
        send_command(CMD_INSERT, 32'sd0);
        send_command(CMD_INSERT, -32'sd1);
        send_command(CMD_INSERT, 32'sh8000_0000);
        send_command(CMD_INSERT, 32'sh7FFF_FFFF);
        send_command(CMD_INSERT, 32'sh7FFF_FFFF);
        send_command(CMD_PEEK, 32'sd0);
        repeat (6)
            send_command(CMD_EXTRACT, 32'sd0);
        send_command(CMD_INSERT, 32'sh8000_0000);
        send_command(CMD_INSERT, 32'sh5555_5555);
        send_command(CMD_INSERT, -32'sh5555_5556);
        send_command(CMD_CLEAR, 32'sd0);
        send_command(CMD_PEEK, 32'sd0);
        send_command(CMD_EXTRACT, 32'sd0);
    endtask

    task automatic test_full_heap();
        repeat (CAPACITY)
            send_command(CMD_INSERT, pick_value());
        send_command(CMD_INSERT, 32'sh7FFF_FFFF);
        send_command(CMD_INSERT, pick_value());
        send_command(CMD_PEEK, 32'sd0);
        repeat (CAPACITY)
            send_command(CMD_EXTRACT, pick_value());
        send_command(CMD_EXTRACT, 32'sd0);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count)
            send_command(pick_command(shadow_fill < 4 ? 70 : 48), pick_value());
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.command = CMD_PEEK;
        cmd_if.value   = '0;
        res_if.ready   = 1'b0;
        idle_on        = 1'b1;
        shadow_fill    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_empty_heap();
        test_extreme_values();
        test_full_heap();
        test_random_mix(290);
        // closing stretch with no idling on either channel
        idle_on = 1'b0;
        test_random_mix(80);
        cmd_if.valid <= 1'b0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d inserts (%0d dropped when full), %0d extracts (%0d on an empty heap)",
                 n_insert, n_dropped, n_extract, n_ignored);
        $display("plus %0d clears and %0d peeks; %0d result transactions checked",
                 n_clear, n_peek, answers_checked);
        if (error_count == 0)
            $display("max_heap_priority_queue verification clean");
        else
            $display("max_heap_priority_queue verification failed");
        $finish;
    end

    // result sink with random stall bursts
    always @(negedge clk)
    begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 13);
        if (stall_left > 0)
        begin
            stall_left--;
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        heap_answer_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("unexpected result transaction", '0, res_if.top_value);
            else
            begin
                want = pending_answers.pop_front();
                answers_checked++;
                if (res_if.top_value !== want.top_value)
                    report_mismatch("top_value", want.top_value, res_if.top_value);
                if (res_if.entry_count !== want.entry_count)
                    report_mismatch("entry_count", want.entry_count, res_if.entry_count);
                if (res_if.status !== want.status)
                    report_mismatch("status", want.status, res_if.status);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results outstanding", $realtime,
                     pending_answers.size());
            $display("max_heap_priority_queue verification failed");
            $finish;
        end
    end

endmodule
`default_nettype wire

// File: sim.f
rtl/mhpq_pkg.sv
rtl/mhpq_cmd_if.sv
rtl/mhpq_res_if.sv
rtl/mhpq_datapath.sv
rtl/mhpq_ctrl.sv
rtl/max_heap_priority_queue.sv
tb/max_heap_priority_queue_tb.sv
